FILE: design/qsvge_pkg.sv
// Package for the qubit state-vector gate engine.
// Holds item types, opcodes, status codes, the datapath command type and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package qsvge_pkg;
    localparam int MaxQubits = 6;
    localparam int AmpWidth  = 16;
    localparam int FracBits  = 14;
    localparam int VecDepth  = 1 << MaxQubits;
    localparam int IdxW      = MaxQubits;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_GATE  = 3'd1;
    localparam logic [2:0] OP_CGATE = 3'd2;
    localparam logic [2:0] OP_SWAP  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAME  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         target;
        logic [2:0]         control;
        logic [5:0]         basis_index;
        logic signed [15:0] m00_re;
        logic signed [15:0] m00_im;
        logic signed [15:0] m01_re;
        logic signed [15:0] m01_im;
        logic signed [15:0] m10_re;
        logic signed [15:0] m10_im;
        logic signed [15:0] m11_re;
        logic signed [15:0] m11_im;
    } in_item_t;

    typedef struct packed {
        logic [5:0]         amp_index;
        logic signed [15:0] amp_re;
        logic signed [15:0] amp_im;
        logic [1:0]         status;
        logic               last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic            mem_we;
        logic [IdxW-1:0] mem_waddr;
        logic            wsel_new;   // 1: write new amp, 0: write basis value
        logic            wsel_one;   // basis value is one (else zero)
        logic            wsel_b;     // new amp of second index
        logic            rd_en;
        logic [IdxW-1:0] raddr;
        logic            lat_a;      // latch read data as first operand
        logic            lat_b;      // latch read data as second operand
        logic            calc;       // compute products
    } dp_cmd_t;
endpackage

FILE: design/qsvge_datapath.sv
// Datapath: amplitude memory, complex multiply-accumulate, rounding and saturation.
// Depends on qsvge_pkg.
`timescale 1ns / 1ps
module qsvge_datapath
    import qsvge_pkg::*;
(
    input  logic                       clk,
    input  dp_cmd_t                    cmd,
    input  in_item_t                   gate,
    output logic signed [AmpWidth-1:0] rd_re,
    output logic signed [AmpWidth-1:0] rd_im
);
    logic signed [2*AmpWidth-1:0] mem [VecDepth];
    logic signed [AmpWidth-1:0] rdre_reg, rdim_reg;
    logic signed [AmpWidth-1:0] are_reg, aim_reg, bre_reg, bim_reg;
    logic signed [AmpWidth-1:0] na_re_reg, na_im_reg, nb_re_reg, nb_im_reg;
    logic signed [AmpWidth-1:0] wr_re, wr_im;

    function automatic logic signed [AmpWidth-1:0] rnd_sat(
        input logic signed [AmpWidth+19:0] s);
        logic signed [AmpWidth+19:0] t;
        logic signed [AmpWidth+5:0]  q;
        begin
            t = s + (AmpWidth+20)'(1 << (FracBits-1));
            q = t[AmpWidth+19:FracBits];
            if (q > (AmpWidth+6)'((1 << (AmpWidth-1)) - 1))
                rnd_sat = {1'b0, {(AmpWidth-1){1'b1}}};
            else if (q < -(AmpWidth+6)'(1 << (AmpWidth-1)))
                rnd_sat = {1'b1, {(AmpWidth-1){1'b0}}};
            else
                rnd_sat = q[AmpWidth-1:0];
        end
    endfunction

    function automatic logic signed [AmpWidth+19:0] cmac(
        input logic signed [15:0] xr, input logic signed [15:0] xi,
        input logic signed [15:0] yr, input logic signed [15:0] yi,
        input logic signed [AmpWidth-1:0] ar, input logic signed [AmpWidth-1:0] ai,
        input logic signed [AmpWidth-1:0] br, input logic signed [AmpWidth-1:0] bi,
        input logic imag);
        logic signed [AmpWidth+19:0] p0, p1, p2, p3;
        begin
            p0 = imag ? (AmpWidth+20)'(xr * ai) : (AmpWidth+20)'(xr * ar);
            p1 = imag ? (AmpWidth+20)'(xi * ar) : -(AmpWidth+20)'(xi * ai);
            p2 = imag ? (AmpWidth+20)'(yr * bi) : (AmpWidth+20)'(yr * br);
            p3 = imag ? (AmpWidth+20)'(yi * br) : -(AmpWidth+20)'(yi * bi);
            cmac = p0 + p1 + p2 + p3;
        end
    endfunction

    always_comb
    begin
        if (!cmd.wsel_new)
        begin
            wr_re = cmd.wsel_one ? AmpWidth'(1 << FracBits) : '0;
            wr_im = '0;
        end
        else if (cmd.wsel_b)
        begin
            wr_re = nb_re_reg;
            wr_im = nb_im_reg;
        end
        else
        begin
            wr_re = na_re_reg;
            wr_im = na_im_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[cmd.mem_waddr] <= {wr_re, wr_im};
        if (cmd.rd_en)
            {rdre_reg, rdim_reg} <= mem[cmd.raddr];
        if (cmd.lat_a)
        begin
            are_reg <= rdre_reg;
            aim_reg <= rdim_reg;
        end
        if (cmd.lat_b)
        begin
            bre_reg <= rdre_reg;
            bim_reg <= rdim_reg;
        end
        if (cmd.calc)
        begin
            na_re_reg <= rnd_sat(cmac(gate.m00_re, gate.m00_im, gate.m01_re, gate.m01_im,
                                      are_reg, aim_reg, bre_reg, bim_reg, 1'b0));
            na_im_reg <= rnd_sat(cmac(gate.m00_re, gate.m00_im, gate.m01_re, gate.m01_im,
                                      are_reg, aim_reg, bre_reg, bim_reg, 1'b1));
            nb_re_reg <= rnd_sat(cmac(gate.m10_re, gate.m10_im, gate.m11_re, gate.m11_im,
                                      are_reg, aim_reg, bre_reg, bim_reg, 1'b0));
            nb_im_reg <= rnd_sat(cmac(gate.m10_re, gate.m10_im, gate.m11_re, gate.m11_im,
                                      are_reg, aim_reg, bre_reg, bim_reg, 1'b1));
        end
    end

    assign rd_re = rdre_reg;
    assign rd_im = rdim_reg;
endmodule

FILE: design/qsvge_ctrl.sv
// Controller: sequences clears, gate pair walks, swaps and readout.
// Depends on qsvge_pkg.
`timescale 1ns / 1ps
module qsvge_ctrl
    import qsvge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output in_item_t          gate,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    output dp_cmd_t           cmd,
    input  logic signed [AmpWidth-1:0] rd_re,
    input  logic signed [AmpWidth-1:0] rd_im
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_RDA, S_RDB, S_LATB, S_CALC, S_WRA, S_WRB,
        S_RDOUT, S_RDWAIT, S_OUT, S_ACK
    } state_t;

    state_t state_reg;
    logic [IdxW:0]   cnt_reg;
    logic [IdxW-1:0] idx_reg, jdx_reg, one_reg;
    logic [2:0]      n_reg;        // effective qubit count
    logic [IdxW-1:0] tmask_reg, cmask_reg;
    logic            swap_reg;
    in_item_t        item_reg;
    out_item_t       out_reg;
    logic            ov_reg;
    logic            init_reg;
    logic            busy_ok;

    logic [IdxW:0]   len;
    logic [IdxW-1:0] lmask, tm, cm, i_cur;
    logic [2:0]      ncfg;
    logic            t_bad, c_bad;
    logic [1:0]      acc_status;
    in_item_t        swap_item;

    assign len   = (IdxW+1)'(1) << n_reg;
    assign lmask = IdxW'(len - 1'b1);
    assign tm    = IdxW'(1) << (n_reg - 3'd1 - in_data.target);
    assign cm    = IdxW'(1) << (n_reg - 3'd1 - in_data.control);
    assign t_bad = in_data.target >= n_reg;
    assign c_bad = in_data.control >= n_reg;
    assign ncfg  = (cfg_data == 3'd0) ? 3'd1 :
                   (cfg_data > 3'(MaxQubits)) ? 3'(MaxQubits) : cfg_data;
    assign i_cur = cnt_reg[IdxW-1:0];

    assign busy_ok   = (state_reg == S_IDLE) && !ov_reg;
    assign in_stall  = !busy_ok;
    // an offered item has priority over a register write
    assign cfg_ready = busy_ok && !in_valid;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign gate      = item_reg;

    // swaps use a fixed permutation matrix held in the item register
    always_comb
    begin
        swap_item        = in_data;
        swap_item.m00_re = '0;
        swap_item.m00_im = '0;
        swap_item.m01_re = 16'sd16384;
        swap_item.m01_im = '0;
        swap_item.m10_re = 16'sd16384;
        swap_item.m10_im = '0;
        swap_item.m11_re = '0;
        swap_item.m11_im = '0;
    end

    // range check first, then control equal to target
    always_comb
    begin
        acc_status = ST_OK;
        case (in_data.opcode)
            OP_GATE:
            begin
                if (t_bad)
                    acc_status = ST_RANGE;
            end
            OP_CGATE, OP_SWAP:
            begin
                if (t_bad || c_bad)
                    acc_status = ST_RANGE;
                else if (in_data.target == in_data.control)
                    acc_status = ST_SAME;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_we    = 1'b1;
                cmd.mem_waddr = i_cur;
                cmd.wsel_one  = (i_cur == one_reg);
            end
            S_RDA:
            begin
                cmd.rd_en = 1'b1;
                cmd.raddr = idx_reg;
            end
            S_RDB:
            begin
                cmd.rd_en = 1'b1;
                cmd.raddr = jdx_reg;
                cmd.lat_a = 1'b1;
            end
            S_LATB: cmd.lat_b = 1'b1;
            S_CALC: cmd.calc = 1'b1;
            S_WRA:
            begin
                cmd.mem_we    = 1'b1;
                cmd.mem_waddr = idx_reg;
                cmd.wsel_new  = 1'b1;
            end
            S_WRB:
            begin
                cmd.mem_we    = 1'b1;
                cmd.mem_waddr = jdx_reg;
                cmd.wsel_new  = 1'b1;
                cmd.wsel_b    = 1'b1;
            end
            S_RDOUT:
            begin
                cmd.rd_en = 1'b1;
                cmd.raddr = i_cur;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            one_reg   <= '0;
            n_reg     <= 3'd1;
            ov_reg    <= 1'b0;
            init_reg  <= 1'b0;
            idx_reg   <= '0;
            jdx_reg   <= '0;
            tmask_reg <= '0;
            cmask_reg <= '0;
            swap_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_RDWAIT || state_reg == S_ACK)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (state_reg == S_IDLE)
                init_reg <= in_valid && !in_stall && in_data.opcode == OP_INIT;
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    // clears after reset or configuration give no acknowledgement
                    if (cnt_reg == (IdxW+1)'(VecDepth - 1))
                        state_reg <= init_reg ? S_ACK : S_IDLE;
                end
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        n_reg     <= ncfg;
                        one_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_CLEAR;
                    end
                    else if (in_valid && !in_stall)
                    begin
                        item_reg  <= (in_data.opcode == OP_SWAP) ? swap_item : in_data;
                        cnt_reg   <= '0;
                        out_reg   <= {6'd0, 16'sd0, 16'sd0, acc_status, 1'b1};
                        tmask_reg <= tm;
                        cmask_reg <= (in_data.opcode inside {OP_CGATE, OP_SWAP}) ? cm : '0;
                        swap_reg  <= (in_data.opcode == OP_SWAP);
                        case (in_data.opcode)
                            OP_INIT:
                            begin
                                one_reg   <= in_data.basis_index & lmask;
                                state_reg <= S_CLEAR;
                            end
                            OP_GATE, OP_CGATE, OP_SWAP:
                                state_reg <= (acc_status == ST_OK) ? S_SCAN : S_ACK;
                            OP_READ: state_reg <= S_RDOUT;
                            default: state_reg <= S_ACK;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg == len)
                        state_reg <= S_ACK;
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (swap_reg)
                        begin
                            // cmask: first qubit set, tmask: second clear
                            if ((i_cur & cmask_reg) != '0 && (i_cur & tmask_reg) == '0)
                            begin
                                idx_reg   <= i_cur;
                                jdx_reg   <= i_cur ^ cmask_reg ^ tmask_reg;
                                state_reg <= S_RDA;
                            end
                        end
                        else if ((i_cur & tmask_reg) == '0
                                 && (i_cur & cmask_reg) == cmask_reg)
                        begin
                            idx_reg   <= i_cur;
                            jdx_reg   <= i_cur | tmask_reg;
                            state_reg <= S_RDA;
                        end
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB: state_reg <= S_LATB;
                S_LATB:
                begin
                    // swap: the permutation matrix in the item register routes b to first, a to second
                    state_reg <= S_CALC;
                end
                S_CALC: state_reg <= S_WRA;
                S_WRA:  state_reg <= S_WRB;
                S_WRB:  state_reg <= S_SCAN;
                S_RDOUT: state_reg <= S_RDWAIT;
                S_RDWAIT:
                begin
                    out_reg   <= {i_cur, rd_re, rd_im, ST_OK, (cnt_reg + 1'b1 == len)};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (out_reg.last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_RDOUT;
                        end
                    end
                end
                S_ACK: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/qubit_state_vector_gate_engine_core.sv
// Top level of the qubit state-vector gate engine.
// Joins qsvge_ctrl and qsvge_datapath; depends on qsvge_pkg.
//
// Channel | Direction | Handshake       | Carries
// in      | in        | in_valid/stall  | in_item_t: opcode, qubits, gate
// out     | out       | out_valid/stall | out_item_t: amplitude, status, last
// cfg     | in        | cfg_valid/ready | qubits_in_use (3 bits)
//
// A gate walks all 2^n indices; each updated pair adds read a, read b, latch b,
// calculate, write a and write b, and a closing scan step ends the walk; init
// writes every entry once; a read passes read, read wait and output per amplitude;
// every non-read item ends with an ack state. Reset and a configuration write both
// run a clearing pass over all 64 memory entries; no item is taken meanwhile. An
// offered item wins over a register write. An output stall holds the sequencer.
`timescale 1ns / 1ps
module qubit_state_vector_gate_engine_core
    import qsvge_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0] cfg_data
);
    dp_cmd_t  cmd;
    in_item_t gate;
    logic signed [AmpWidth-1:0] rd_re, rd_im;

    qsvge_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .gate(gate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cmd(cmd), .rd_re(rd_re), .rd_im(rd_im)
    );

    qsvge_datapath u_dp (
        .clk(clk), .cmd(cmd), .gate(gate),
        .rd_re(rd_re), .rd_im(rd_im)
    );
endmodule

FILE: design/qsvge_checker.sv
// Port checker for the gate engine, bound to the top level.
// Depends on qsvge_pkg.
`timescale 1ns / 1ps
module qsvge_checker
    import qsvge_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data,
    input logic      cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall)
        else $error("config and input readiness disagree");
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.last)
        else $error("error status on non-final result");
endmodule

bind qubit_state_vector_gate_engine_core qsvge_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_ready(cfg_ready)
);
